### design/mme_pkg.sv
package mme_pkg;

  localparam int DIM_W     = 4;
  localparam int IDX_W     = 3;
  localparam int VAL_W     = 16;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 24;

  localparam logic [MODE_W-1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_B  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_ROWS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 2'd3;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             mac_vld;
    logic             mac_first;
    logic [IDX_W-1:0] i_idx;
    logic [IDX_W-1:0] j_idx;
    logic [IDX_W-1:0] k_idx;
    logic             emit;
    logic             emit_err;
    logic             emit_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

### design/mme_ctrl.sv
module mme_ctrl #(
  parameter int MAX_DIM = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mme_pkg::MODE_W-1:0]     in_mode,
  input  logic [mme_pkg::IDX_W-1:0]      in_row,
  input  logic [mme_pkg::IDX_W-1:0]      in_col,
  input  logic                           cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]      cfg_data,
  input  mme_pkg::status_t               status,
  output mme_pkg::cmd_t                  cmd
);
  import mme_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MAC   = 3'd1;
  localparam logic [2:0] ST_FLUSH = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_ERR   = 3'd4;

  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic             fl_r, fl_nxt;
  logic [DIM_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [DIM_W-1:0] cfg_clamped;
  logic             in_acc, last_i, last_j, last_k;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = DIM_W'(1);
    end else if (cfg_data > DIM_MAX) begin
      cfg_clamped = DIM_MAX;
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= DIM_W'(1);
      a_cols_r <= DIM_W'(1);
      b_rows_r <= DIM_W'(1);
      b_cols_r <= DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_A_ROWS: a_rows_r <= cfg_clamped;
        CFG_A_COLS: a_cols_r <= cfg_clamped;
        CFG_B_ROWS: b_rows_r <= cfg_clamped;
        CFG_B_COLS: b_cols_r <= cfg_clamped;
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign last_i    = ({1'b0, i_r} + DIM_W'(1)) == a_rows_r;
  assign last_j    = ({1'b0, j_r} + DIM_W'(1)) == b_cols_r;
  assign last_k    = ({1'b0, k_r} + DIM_W'(1)) == a_cols_r;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    fl_nxt    = fl_r;
    cmd       = '0;
    cmd.i_idx = i_r;
    cmd.j_idx = j_r;
    cmd.k_idx = k_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_mode)
            MODE_LOAD_A: begin
              cmd.wr_a = ({1'b0, in_row} < a_rows_r) && ({1'b0, in_col} < a_cols_r);
            end
            MODE_LOAD_B: begin
              cmd.wr_b = ({1'b0, in_row} < b_rows_r) && ({1'b0, in_col} < b_cols_r);
            end
            MODE_COMPUTE: begin
              i_nxt = '0;
              j_nxt = '0;
              k_nxt = '0;
              state_nxt = (a_cols_r != b_rows_r) ? ST_ERR : ST_MAC;
            end
            MODE_UNUSED: ;
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd.mac_vld   = 1'b1;
        cmd.mac_first = (k_r == '0);
        if (last_k) begin
          k_nxt     = '0;
          fl_nxt    = 1'b0;
          state_nxt = ST_FLUSH;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      ST_FLUSH: begin
        fl_nxt = 1'b1;
        if (fl_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = last_i && last_j;
          if (last_j) begin
            j_nxt = '0;
            i_nxt = i_r + IDX_W'(1);
          end else begin
            j_nxt = j_r + IDX_W'(1);
          end
          state_nxt = (last_i && last_j) ? ST_IDLE : ST_MAC;
        end
      end
      ST_ERR: begin
        if (status.out_free) begin
          cmd.emit_err  = 1'b1;
          cmd.emit_last = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      fl_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      fl_r    <= fl_nxt;
    end
  end

endmodule

### design/mme_datapath.sv
module mme_datapath #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mme_pkg::cmd_t                  cmd,
  output mme_pkg::status_t               status,
  input  logic [mme_pkg::IDX_W-1:0]      in_row,
  input  logic [mme_pkg::IDX_W-1:0]      in_col,
  input  logic [mme_pkg::VAL_W-1:0]      in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mme_pkg::IDX_W-1:0]      out_row,
  output logic [mme_pkg::IDX_W-1:0]      out_col,
  output logic [mme_pkg::VAL_W-1:0]      out_value,
  output logic                           out_sat,
  output logic                           out_dim_error,
  output logic                           out_last
);
  import mme_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = 2 * VAL_W;
  localparam int ACC_W = PW + $clog2(MAX_DIM) + 1;
  localparam logic signed [ACC_W-1:0] POS_LIM = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] NEG_LIM = ACC_W'(-32768);

  logic [VAL_W-1:0] store_a [DEPTH];
  logic [VAL_W-1:0] store_b [DEPTH];

  logic [AW-1:0]           wr_addr, a_addr, b_addr;
  logic [VAL_W-1:0]        a_rd_r, b_rd_r;
  logic                    rd_vld_r, rd_first_r, pr_vld_r, pr_first_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r, shifted;
  logic                    sat_hi, sat_lo;
  logic [VAL_W-1:0]        clipped;
  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_row_r, out_col_r;
  logic [VAL_W-1:0]        out_value_r;
  logic                    out_sat_r, out_err_r, out_last_r;

  assign wr_addr = AW'(int'(in_row) * MAX_DIM + int'(in_col));
  assign a_addr  = AW'(int'(cmd.i_idx) * MAX_DIM + int'(cmd.k_idx));
  assign b_addr  = AW'(int'(cmd.k_idx) * MAX_DIM + int'(cmd.j_idx));

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      store_a[wr_addr] <= in_value;
    end
    if (cmd.mac_vld) begin
      a_rd_r <= store_a[a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_b) begin
      store_b[wr_addr] <= in_value;
    end
    if (cmd.mac_vld) begin
      b_rd_r <= store_b[b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      pr_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.mac_vld;
      pr_vld_r <= rd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_first_r <= cmd.mac_first;
    pr_first_r <= rd_first_r;
    if (rd_vld_r) begin
      prod_r <= $signed(a_rd_r) * $signed(b_rd_r);
    end
    if (pr_vld_r) begin
      acc_r <= pr_first_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
  end

  assign shifted = acc_r >>> FRAC_BITS;
  assign sat_hi  = shifted > POS_LIM;
  assign sat_lo  = shifted < NEG_LIM;

  always_comb begin
    if (sat_hi) begin
      clipped = VAL_W'(POS_LIM);
    end else if (sat_lo) begin
      clipped = VAL_W'(NEG_LIM);
    end else begin
      clipped = shifted[VAL_W-1:0];
    end
  end

  assign status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_err) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r   <= cmd.i_idx;
      out_col_r   <= cmd.j_idx;
      out_value_r <= clipped;
      out_sat_r   <= sat_hi || sat_lo;
      out_err_r   <= 1'b0;
      out_last_r  <= cmd.emit_last;
    end else if (cmd.emit_err) begin
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_value_r <= '0;
      out_sat_r   <= 1'b0;
      out_err_r   <= 1'b1;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_value     = out_value_r;
  assign out_sat       = out_sat_r;
  assign out_dim_error = out_err_r;
  assign out_last      = out_last_r;

endmodule

### design/matrix_multiply_engine_unit.sv
// Channel   Direction  Contents
// in_*      input      tuser: mode; tdata: row, col, value
// out_*     output     tuser: dim_error; tdata: out_row, out_col, out_value, saturated;
//                      tlast: last
// cfg_*     input      write enable, register index, 4-bit register value
//
// A load item or an unused mode leaves the block idle. A compute item works through each
// product element in the MAC state, one multiply-accumulate per cycle, set by the single
// read port of each element store, then waits in the flush state for the read and
// multiply stages. A dimension error sends one error item. A finished element
// waits in the output register while out_tready is low; the next element is computed
// meanwhile and is held until the register frees.
// Reset is synchronous and clears control state only; the element stores are not cleared.
module matrix_multiply_engine_unit #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Bits from lowest: row[2:0], col[5:3], value[21:6], zero fill.
  input  logic [mme_pkg::IN_W-1:0]          in_tdata,
  // Bits from lowest: mode[1:0].
  input  logic [mme_pkg::MODE_W-1:0]        in_tuser,
  input  logic                              cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]         cfg_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Bits from lowest: out_row[2:0], out_col[5:3], out_value[21:6], saturated[22], zero fill.
  output logic [mme_pkg::OUT_W-1:0]         out_tdata,
  // Bits from lowest: dim_error[0].
  output logic [0:0]                        out_tuser,
  output logic                              out_tlast
);
  import mme_pkg::*;

  cmd_t             cmd;
  status_t          status;
  logic [IDX_W-1:0] in_row, in_col, o_row, o_col;
  logic [VAL_W-1:0] in_value, o_value;
  logic             o_sat, o_err;

  assign in_row   = in_tdata[2:0];
  assign in_col   = in_tdata[5:3];
  assign in_value = in_tdata[21:6];

  mme_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tuser),
    .in_row    (in_row),
    .in_col    (in_col),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd)
  );

  mme_datapath #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_value      (in_value),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_row       (o_row),
    .out_col       (o_col),
    .out_value     (o_value),
    .out_sat       (o_sat),
    .out_dim_error (o_err),
    .out_last      (out_tlast)
  );

  assign out_tdata = {1'b0, o_sat, o_value, o_col, o_row};
  assign out_tuser = o_err;

endmodule

### sim/mme_checker.sv
module mme_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [mme_pkg::IN_W-1:0]      in_tdata,
  input  logic [mme_pkg::MODE_W-1:0]    in_tuser,
  input  logic                          cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mme_pkg::DIM_W-1:0]     cfg_data,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [mme_pkg::OUT_W-1:0]     out_tdata,
  input  logic [0:0]                    out_tuser,
  input  logic                          out_tlast,
  output int                            fail_count,
  output int                            exp_count,
  output int                            results_seen
);
  import mme_pkg::*;

  localparam int MAX_DIM   = 8;
  localparam int FRAC_BITS = 8;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             sat;
    logic             err;
    logic             last;
  } product_t;

  product_t          product_q[$];
  logic signed [15:0] elem_a[MAX_DIM*MAX_DIM];
  logic signed [15:0] elem_b[MAX_DIM*MAX_DIM];
  int unsigned       n_arows, n_acols, n_brows, n_bcols;

  function automatic int unsigned clamp_size(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return 32'(v);
  endfunction

  function automatic logic [2*IDX_W-1:0] elem_addr(logic [IDX_W-1:0] row,
                                                   logic [IDX_W-1:0] col);
    return {row, col};
  endfunction

  task automatic report(string field, int got, int want);
    $display("MISMATCH result %0d: %s got %0d, expected %0d", results_seen, field, got, want);
    fail_count++;
  endtask

  task automatic predict_product();
    longint   acc;
    longint   r;
    product_t p;
    if (n_acols != n_brows) begin
      p = '0;
      p.err = 1'b1;
      p.last = 1'b1;
      product_q.push_back(p);
      return;
    end
    for (int i = 0; i < n_arows; i++) begin
      for (int j = 0; j < n_bcols; j++) begin
        acc = 0;
        for (int k = 0; k < n_acols; k++)
          acc += longint'(elem_a[elem_addr(i[IDX_W-1:0], k[IDX_W-1:0])]) *
                 longint'(elem_b[elem_addr(k[IDX_W-1:0], j[IDX_W-1:0])]);
        r = acc >>> FRAC_BITS;
        p = '0;
        p.row = i[IDX_W-1:0];
        p.col = j[IDX_W-1:0];
        if (r > 32767) begin
          r = 32767;
          p.sat = 1'b1;
        end else if (r < -32768) begin
          r = -32768;
          p.sat = 1'b1;
        end
        p.value = r[VAL_W-1:0];
        p.last = (i + 1 == n_arows) && (j + 1 == n_bcols);
        product_q.push_back(p);
      end
    end
  endtask

  task automatic check_result();
    product_t want;
    logic [IDX_W-1:0] g_row, g_col;
    logic signed [VAL_W-1:0] g_val;
    g_row = out_tdata[2:0];
    g_col = out_tdata[5:3];
    g_val = out_tdata[21:6];
    if (product_q.size() == 0) begin
      report("unexpected item, row", int'(g_row), -1);
    end else begin
      want = product_q.pop_front();
      if (g_row != want.row) report("out_row", int'(g_row), int'(want.row));
      if (g_col != want.col) report("out_col", int'(g_col), int'(want.col));
      if (g_val != want.value) report("out_value", int'(g_val), int'($signed(want.value)));
      if (out_tdata[22] != want.sat) report("saturated", int'(out_tdata[22]), int'(want.sat));
      if (out_tuser[0] != want.err) report("dim_error", int'(out_tuser[0]), int'(want.err));
      if (out_tlast != want.last) report("last", int'(out_tlast), int'(want.last));
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      n_arows = 1;
      n_acols = 1;
      n_brows = 1;
      n_bcols = 1;
      fail_count = 0;
      results_seen = 0;
      product_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_A_ROWS: n_arows = clamp_size(cfg_data);
          CFG_A_COLS: n_acols = clamp_size(cfg_data);
          CFG_B_ROWS: n_brows = clamp_size(cfg_data);
          CFG_B_COLS: n_bcols = clamp_size(cfg_data);
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          MODE_LOAD_A:
            if (in_tdata[2:0] < n_arows && in_tdata[5:3] < n_acols)
              elem_a[elem_addr(in_tdata[2:0], in_tdata[5:3])] = in_tdata[21:6];
          MODE_LOAD_B:
            if (in_tdata[2:0] < n_brows && in_tdata[5:3] < n_bcols)
              elem_b[elem_addr(in_tdata[2:0], in_tdata[5:3])] = in_tdata[21:6];
          MODE_COMPUTE: predict_product();
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) check_result();
    end
    exp_count <= product_q.size();
  end

endmodule

### sim/tb_top.sv
module tb_top;
  import mme_pkg::*;

  localparam int RANDOM_ITEMS   = 220;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic [MODE_W-1:0]    in_tuser = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]     cfg_data = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic [0:0]           out_tuser;
  logic                 out_tlast;

  int  fail_count, exp_count, results_seen;
  bit  idle_on = 1'b0;
  int  stall_left = 0;
  int  quiet = 0;
  int  ar = 1, ac = 1, br = 1, bc = 1;
  bit  a_ok[64];
  bit  b_ok[64];
  int  sent_total = 0, dim_errs = 0, products = 0, settings = 0;

  always #4 clk = ~clk;

  matrix_multiply_engine_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  mme_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .fail_count(fail_count), .exp_count(exp_count), .results_seen(results_seen)
  );

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic int eff_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > 8) return 8;
    return int'(v);
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int s;
    s = $urandom_range(0, 9);
    if (s == 0) return DIM_W'($urandom_range(9, 15));
    if (s == 1) return '0;
    if (s == 2) return DIM_W'(8);
    return DIM_W'($urandom_range(1, 4));
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int s;
    s = $urandom_range(0, 9);
    if (s < 4) return VAL_W'($urandom);
    if (s < 8) return VAL_W'($urandom_range(0, 1023) - 512);
    if (s == 8) return 16'h7FFF;
    return 16'h8000;
  endfunction

  function automatic logic [2*IDX_W-1:0] slot(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
    return {row, col};
  endfunction

  task automatic send_item(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] row,
                           logic [IDX_W-1:0] col, logic [VAL_W-1:0] value);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= mode;
    in_tdata <= {2'b00, value, col, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_total++;
    case (mode)
      MODE_LOAD_A:
        if (row < ar && col < ac) begin
          a_ok[slot(row, col)] = 1'b1;
        end
      MODE_LOAD_B:
        if (row < br && col < bc) begin
          b_ok[slot(row, col)] = 1'b1;
        end
      MODE_COMPUTE: begin
        if (ac != br) dim_errs++;
        else products += ar * bc;
      end
      default: ;
    endcase
  endtask

  // A product may only read elements that were loaded since reset.
  task automatic compute();
    if (ac == br) begin
      for (int i = 0; i < ar; i++)
        for (int k = 0; k < ac; k++)
          if (!a_ok[slot(IDX_W'(i), IDX_W'(k))])
            send_item(MODE_LOAD_A, IDX_W'(i), IDX_W'(k), pick_value());
      for (int k = 0; k < br; k++)
        for (int j = 0; j < bc; j++)
          if (!b_ok[slot(IDX_W'(k), IDX_W'(j))])
            send_item(MODE_LOAD_B, IDX_W'(k), IDX_W'(j), pick_value());
    end
    send_item(MODE_COMPUTE, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
  endtask

  task automatic random_load();
    bit which;
    int nr, nc;
    logic [IDX_W-1:0] r, c;
    which = 1'($urandom_range(0, 1));
    nr = which ? br : ar;
    nc = which ? bc : ac;
    if ($urandom_range(0, 5) == 0) begin
      r = IDX_W'($urandom);
      c = IDX_W'($urandom);
    end else begin
      r = IDX_W'($urandom_range(0, nr - 1));
      c = IDX_W'($urandom_range(0, nc - 1));
    end
    send_item(which ? MODE_LOAD_B : MODE_LOAD_A, r, c, pick_value());
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (exp_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [DIM_W-1:0] r_a, logic [DIM_W-1:0] c_a,
                           logic [DIM_W-1:0] r_b, logic [DIM_W-1:0] c_b);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_A_ROWS;
    cfg_data <= r_a;
    @(posedge clk);
    cfg_index <= CFG_A_COLS;
    cfg_data <= c_a;
    @(posedge clk);
    cfg_index <= CFG_B_ROWS;
    cfg_data <= r_b;
    @(posedge clk);
    cfg_index <= CFG_B_COLS;
    cfg_data <= c_b;
    @(posedge clk);
    cfg_we <= 1'b0;
    ar = eff_dim(r_a);
    ac = eff_dim(c_a);
    br = eff_dim(r_b);
    bc = eff_dim(c_b);
    settings++;
  endtask

  initial begin : stimulus
    logic [DIM_W-1:0] ra, ca, rb, cb;
    int ops, s;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Saturation in both directions and rounding toward minus infinity on 1x1 products.
    send_item(MODE_LOAD_A, 3'd0, 3'd0, 16'h7FFF);
    send_item(MODE_LOAD_B, 3'd0, 3'd0, 16'h7FFF);
    compute();
    send_item(MODE_LOAD_A, 3'd0, 3'd0, 16'h8000);
    compute();
    send_item(MODE_LOAD_B, 3'd0, 3'd0, 16'h8000);
    compute();
    send_item(MODE_LOAD_A, 3'd0, 3'd0, 16'hFFFF);
    send_item(MODE_LOAD_B, 3'd0, 3'd0, 16'h0001);
    compute();
    // Loads outside the size are dropped and the unused mode does nothing.
    send_item(MODE_LOAD_A, 3'd1, 3'd0, 16'h1234);
    send_item(MODE_LOAD_B, 3'd0, 3'd7, 16'h4321);
    send_item(MODE_UNUSED, 3'd7, 3'd7, 16'hFFFF);
    compute();
    // Out-of-range sizes clamp, leaving a dimension mismatch.
    configure(4'd0, 4'd15, 4'd0, 4'd15);
    compute();
    configure(4'd2, 4'd1, 4'd1, 4'd2);
    compute();

    idle_on = 1'b1;
    while (sent_total < RANDOM_ITEMS) begin
      if (sent_total > RANDOM_ITEMS * 4 / 5) idle_on = 1'b0;
      ra = pick_dim();
      ca = pick_dim();
      rb = ($urandom_range(0, 4) == 0) ? pick_dim() : ca;
      cb = pick_dim();
      configure(ra, ca, rb, cb);
      ops = $urandom_range(4, 14);
      repeat (ops) begin
        s = $urandom_range(0, 19);
        if (s < 12) random_load();
        else if (s < 14) send_item(MODE_UNUSED, IDX_W'($urandom), IDX_W'($urandom),
                                   VAL_W'($urandom));
        else compute();
      end
      compute();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (exp_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Sent %0d input items over %0d size settings; %0d product elements, %0d size errors.",
             sent_total, settings, products, dim_errs);
    $display("Checked %0d result items with %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0 && exp_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
design/mme_pkg.sv
design/mme_ctrl.sv
design/mme_datapath.sv
design/matrix_multiply_engine_unit.sv
sim/mme_checker.sv
sim/tb_top.sv
